// File: sv/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg
// Shared types and constants of the binary max-heap engine.
// ----------------------------------------------------------------------------
package bmh_pkg;

    localparam int unsigned DEPTH  = 256;
    localparam int unsigned AW     = $clog2(DEPTH);
    localparam int unsigned CW     = AW + 1;
    localparam int unsigned KW     = 32;

    localparam logic signed [KW-1:0] KEY_MAX = {1'b0, {(KW-1){1'b1}}};
    localparam logic signed [KW-1:0] KEY_MIN = {1'b1, {(KW-1){1'b0}}};

    typedef logic [2:0]         t_kind;
    typedef logic [1:0]         t_status;
    typedef logic signed [KW-1:0] t_key;
    typedef logic [AW-1:0]      t_addr;
    typedef logic [CW-1:0]      t_count;

    localparam t_kind KIND_INSERT  = 3'd0;
    localparam t_kind KIND_EXTRACT = 3'd1;
    localparam t_kind KIND_DELETE  = 3'd2;
    localparam t_kind KIND_SEARCH  = 3'd3;
    localparam t_kind KIND_INCR    = 3'd4;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_BAD_IDX  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_START,
        S_EX_LD,
        S_DN_RL,
        S_DN_RR,
        S_DN_RC,
        S_SR_RD,
        S_SR_CMP,
        S_FIN
    } t_state;

endpackage

// File: sv/bmh_if.sv
// ----------------------------------------------------------------------------
// bmh channel interfaces
// Valid/ready channels for operations, results and the capacity register.
// ----------------------------------------------------------------------------
interface bmh_in_if;
    import bmh_pkg::*;
    logic  valid;
    logic  ready;
    t_kind kind;
    t_key  key;
    t_addr index;
    modport source (output valid, kind, key, index, input ready);
    modport sink   (input valid, kind, key, index, output ready);
endinterface

interface bmh_out_if;
    import bmh_pkg::*;
    logic             valid;
    logic             ready;
    t_status          status;
    t_key             value;
    logic             found;
    t_count           count;
    t_key             top;
    logic signed [4:0] height;
    modport source (output valid, status, value, found, count, top, height, input ready);
    modport sink   (input valid, status, value, found, count, top, height, output ready);
endinterface

interface bmh_cfg_if;
    import bmh_pkg::*;
    logic   valid;
    logic   ready;
    t_count data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// File: sv/binary_max_heap_engine_top.sv
// Insert and increase key climb level by level; extract moves the last entry to the
// root and descends level by level; delete is both; search reads entry by entry.
// One operation at a time: not ready until the result is registered, and the
// heap memory is single-port.
// Reset: count cleared, capacity 256; heap memory is not cleared.
// ----------------------------------------------------------------------------
// binary_max_heap_engine_top
// Array-backed max-heap priority queue with a small sequencer over one RAM.
// ----------------------------------------------------------------------------
module binary_max_heap_engine_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmh_in_if.sink       i_in,
    bmh_out_if.source    o_out,
    bmh_cfg_if.sink      i_cfg
);
    import bmh_pkg::*;

    t_key   mem [DEPTH];
    t_key   r_rdata;

    t_state r_state, n_state;
    t_count r_count, n_count;
    t_count r_cap;
    t_key   r_root;
    t_key   r_cur, n_cur;
    t_addr  r_pos, n_pos;
    t_key   r_left, n_left;
    t_key   r_key, n_key;
    t_status r_status, n_status;
    t_key   r_value, n_value;
    logic   r_found, n_found;
    logic   r_del, n_del;

    logic   r_o_valid;
    t_status r_o_status;
    t_key   r_o_value;
    logic   r_o_found;
    t_count r_o_count;
    t_key   r_o_top;
    logic signed [4:0] r_o_height;

    logic   we;
    t_addr  addr;
    t_key   wdata;

    t_count limit;
    t_addr  parent;
    logic [AW:0]   lchild;
    logic [AW+1:0] rchild;
    logic   l_ok, r_ok;
    logic   up_move;
    logic   right_big;
    t_key   big_val;
    t_addr  big_pos;
    logic   in_xfer, out_free;
    logic signed [4:0] height;

    assign limit     = (r_cap > t_count'(DEPTH)) ? t_count'(DEPTH) : r_cap;
    assign parent    = (r_pos - t_addr'(1)) >> 1;
    assign lchild    = {r_pos, 1'b1};
    assign rchild    = {1'b0, r_pos, 1'b0} + (AW+2)'(2);
    assign l_ok      = lchild < r_count;
    assign r_ok      = rchild < {1'b0, r_count};
    assign up_move   = r_rdata < r_cur;
    assign right_big = r_rdata > r_left;
    assign big_val   = right_big ? r_rdata : r_left;
    assign big_pos   = right_big ? rchild[AW-1:0] : lchild[AW-1:0];
    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_free  = !r_o_valid || o_out.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.kind)
                        KIND_INSERT:  n_state = (r_count >= limit) ? S_FIN : S_UP_RD;
                        KIND_EXTRACT: n_state = (r_count == '0) ? S_FIN : S_EX_START;
                        KIND_DELETE, KIND_INCR:
                            n_state = ({1'b0, i_in.index} >= r_count) ? S_FIN : S_UP_RD;
                        KIND_SEARCH:  n_state = (r_count == '0) ? S_FIN : S_SR_RD;
                        default:      n_state = S_FIN;
                    endcase
                end
            end
            S_UP_RD:    n_state = (r_pos == '0) ? (r_del ? S_EX_START : S_FIN) : S_UP_CMP;
            S_UP_CMP:   n_state = up_move ? S_UP_RD : (r_del ? S_EX_START : S_FIN);
            S_EX_START: n_state = (r_count == t_count'(1)) ? S_FIN : S_EX_LD;
            S_EX_LD:    n_state = S_DN_RL;
            S_DN_RL:    n_state = l_ok ? S_DN_RR : S_FIN;
            S_DN_RR: begin
                if (r_ok) begin
                    n_state = S_DN_RC;
                end else begin
                    n_state = (r_rdata > r_cur) ? S_DN_RL : S_FIN;
                end
            end
            S_DN_RC:    n_state = (big_val > r_cur) ? S_DN_RL : S_FIN;
            S_SR_RD:    n_state = S_SR_CMP;
            S_SR_CMP: begin
                if (r_rdata == r_key || ({1'b0, r_pos} + t_count'(1)) >= r_count) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SR_RD;
                end
            end
            S_FIN:      n_state = out_free ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_count  = r_count;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_left   = r_left;
        n_key    = r_key;
        n_status = r_status;
        n_value  = r_value;
        n_found  = r_found;
        n_del    = r_del;
        we       = 1'b0;
        addr     = r_pos;
        wdata    = r_cur;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_status = ST_OK;
                    n_value  = KEY_MIN;
                    n_found  = 1'b0;
                    n_del    = 1'b0;
                    n_key    = i_in.key;
                    n_pos    = i_in.index;
                    case (i_in.kind)
                        KIND_INSERT: begin
                            if (r_count >= limit) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                n_cur   = i_in.key;
                                n_pos   = r_count[AW-1:0];
                                n_count = r_count + t_count'(1);
                            end
                        end
                        KIND_EXTRACT: begin
                            if (r_count == '0) n_status = ST_EMPTY;
                        end
                        KIND_DELETE: begin
                            if ({1'b0, i_in.index} >= r_count) n_status = ST_BAD_IDX;
                            n_cur = KEY_MAX;
                            n_del = 1'b1;
                        end
                        KIND_INCR: begin
                            if ({1'b0, i_in.index} >= r_count) n_status = ST_BAD_IDX;
                            n_cur = i_in.key;
                        end
                        KIND_SEARCH: begin
                            n_pos = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    we = 1'b1;
                end else begin
                    addr = parent;
                end
            end
            S_UP_CMP: begin
                we = 1'b1;
                if (up_move) begin
                    wdata = r_rdata;
                    n_pos = parent;
                end
            end
            S_EX_START: begin
                if (!r_del) n_value = r_root;
                n_count = r_count - t_count'(1);
                addr    = n_count[AW-1:0];
            end
            S_EX_LD: begin
                n_cur = r_rdata;
                n_pos = '0;
            end
            S_DN_RL: begin
                if (l_ok) begin
                    addr = lchild[AW-1:0];
                end else begin
                    we = 1'b1;
                end
            end
            S_DN_RR: begin
                n_left = r_rdata;
                if (r_ok) begin
                    addr = rchild[AW-1:0];
                end else begin
                    we = 1'b1;
                    if (r_rdata > r_cur) begin
                        wdata = r_rdata;
                        n_pos = lchild[AW-1:0];
                    end
                end
            end
            S_DN_RC: begin
                we = 1'b1;
                if (big_val > r_cur) begin
                    wdata = big_val;
                    n_pos = big_pos;
                end
            end
            S_SR_CMP: begin
                if (r_rdata == r_key) n_found = 1'b1;
                n_pos = r_pos + t_addr'(1);
            end
            default: ;
        endcase
    end

    // tree height from the msb of the count
    always_comb begin
        height = -5'sd1;
        for (int i = 0; i < CW; i++) begin
            if (r_count[i]) height = 5'(i);
        end
    end

    // heap memory, single port with registered read
    always_ff @(posedge i_clk) begin
        if (we) mem[addr] <= wdata;
        r_rdata <= mem[addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cap     <= t_count'(DEPTH);
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg.valid) r_cap <= i_cfg.data;
            if (r_state == S_FIN && out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_pos    <= n_pos;
        r_left   <= n_left;
        r_key    <= n_key;
        r_status <= n_status;
        r_value  <= n_value;
        r_found  <= n_found;
        r_del    <= n_del;
        // shadow copy of the root entry
        if (we && addr == '0) r_root <= wdata;
        if (r_state == S_FIN && out_free) begin
            r_o_status <= r_status;
            r_o_value  <= r_value;
            r_o_found  <= r_found;
            r_o_count  <= r_count;
            r_o_top    <= (r_count != '0) ? r_root : '0;
            r_o_height <= height;
        end
    end

    assign o_out.valid  = r_o_valid;
    assign o_out.status = r_o_status;
    assign o_out.value  = r_o_value;
    assign o_out.found  = r_o_found;
    assign o_out.count  = r_o_count;
    assign o_out.top    = r_o_top;
    assign o_out.height = r_o_height;

endmodule

// File: dv/tb_binary_max_heap_engine_top.sv
// ----------------------------------------------------------------------------
// tb_binary_max_heap_engine_top
// Drives directed and random heap operations with random gaps, stalls and capacity
// changes and compares every result with a behavioral model of the heap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_binary_max_heap_engine_top;
    import bmh_pkg::*;

    typedef struct packed {
        t_status          status;
        t_key             value;
        logic             found;
        t_count           count;
        t_key             top;
        logic signed [4:0] height;
    } t_heap_result;

    class heap_scoreboard;
        t_key         store [DEPTH];
        int unsigned  held;
        int unsigned  cap;
        t_heap_result pending [$];
        int           errors;

        function new();
            held = 0;
            cap = 256;
            errors = 0;
        endfunction

        function void swap(int unsigned a, int unsigned b);
            t_key t;
            t = store[a];
            store[a] = store[b];
            store[b] = t;
        endfunction

        function void climb(int unsigned pos);
            int unsigned up;
            while (pos != 0) begin
                up = (pos - 1) / 2;
                if (!(store[up] < store[pos])) break;
                swap(pos, up);
                pos = up;
            end
        endfunction

        function void descend(int unsigned pos);
            int unsigned l, r, big;
            forever begin
                l = 2 * pos + 1;
                r = l + 1;
                big = pos;
                if (l < held && store[l] > store[pos]) big = l;
                if (r < held && store[r] > store[big]) big = r;
                if (big == pos) break;
                swap(pos, big);
                pos = big;
            end
        endfunction

        function t_key pop_root();
            t_key root;
            root = store[0];
            held--;
            if (held != 0) begin
                store[0] = store[held];
                descend(0);
            end
            return root;
        endfunction

        function void note_op(t_kind kind, t_key key, t_addr idx);
            t_heap_result r;
            int unsigned limit, n;
            limit = (cap < DEPTH) ? cap : DEPTH;
            r.status = ST_OK;
            r.value = KEY_MIN;
            r.found = 1'b0;
            case (kind)
                KIND_INSERT: begin
                    if (held >= limit) r.status = ST_OVERFLOW;
                    else begin
                        store[held] = key;
                        held++;
                        climb(held - 1);
                    end
                end
                KIND_EXTRACT: begin
                    if (held == 0) r.status = ST_EMPTY;
                    else r.value = pop_root();
                end
                KIND_DELETE: begin
                    if (idx >= held) r.status = ST_BAD_IDX;
                    else begin
                        store[idx] = KEY_MAX;
                        climb(idx);
                        void'(pop_root());
                    end
                end
                KIND_SEARCH: begin
                    for (int i = 0; i < held; i++)
                        if (store[i] == key) r.found = 1'b1;
                end
                KIND_INCR: begin
                    if (idx >= held) r.status = ST_BAD_IDX;
                    else begin
                        store[idx] = key;
                        climb(idx);
                    end
                end
                default: ;
            endcase
            r.count = t_count'(held);
            r.top = held ? store[0] : '0;
            r.height = -1;
            for (n = held; n != 0; n >>= 1) r.height++;
            pending.push_back(r);
        endfunction

        function void check(t_heap_result got);
            t_heap_result e;
            if (pending.size() == 0) begin
                report_err("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status) report_err($sformatf("status %0d exp %0d", got.status, e.status));
            if (got.value !== e.value) report_err($sformatf("value %0d exp %0d", got.value, e.value));
            if (got.found !== e.found) report_err($sformatf("found %0d exp %0d", got.found, e.found));
            if (got.count !== e.count) report_err($sformatf("count %0d exp %0d", got.count, e.count));
            if (got.top !== e.top) report_err($sformatf("top %0d exp %0d", got.top, e.top));
            if (got.height !== e.height) report_err($sformatf("height %0d exp %0d", got.height, e.height));
        endfunction

        function void report_err(string msg);
            errors++;
            if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bmh_in_if  op_ch ();
    bmh_out_if res_ch ();
    bmh_cfg_if cfg_ch ();

    binary_max_heap_engine_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (op_ch.sink),
        .o_out  (res_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    heap_scoreboard sb;
    int  hold_cycles;
    bit  stall_random;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stall plus an optional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sb.check({res_ch.status, res_ch.value, res_ch.found, res_ch.count,
                          res_ch.top, res_ch.height});
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                res_ch.ready <= 1'b0;
            end else if (stall_random) begin
                res_ch.ready <= ($urandom_range(0, 9) < 7);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // starts after the previous transfer, where valid was dropped, plus a random gap under stalls
    task automatic send_op(t_kind kind, t_key key, t_addr idx);
        int g;
        g = stall_random ? gap_len() : 0;
        repeat (g + 1) @(posedge i_clk);
        op_ch.valid <= 1'b1;
        op_ch.kind  <= kind;
        op_ch.key   <= key;
        op_ch.index <= idx;
        do @(posedge i_clk); while (!op_ch.ready);
        sb.note_op(kind, key, idx);
        op_ch.valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(t_count c);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.cap = c;
        @(posedge i_clk);
    endtask

    function automatic t_key rand_key();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return KEY_MAX;
        if (p == 1) return KEY_MIN;
        if (p < 5) return $urandom_range(0, 15) - 8;
        return $urandom();
    endfunction

    task automatic random_op(int ins_weight);
        int p;
        t_addr idx;
        t_key k;
        p = $urandom_range(0, 99);
        idx = (sb.held > 0 && $urandom_range(0, 5) != 0) ? t_addr'($urandom_range(0, sb.held - 1))
                                                        : t_addr'($urandom_range(0, 255));
        k = rand_key();
        // search for a held key half of the time when the heap is not empty
        if (p >= ins_weight + 25 && p < ins_weight + 37 && sb.held > 0 && $urandom_range(0, 1))
            k = sb.store[$urandom_range(0, sb.held - 1)];
        if (p < ins_weight) send_op(KIND_INSERT, k, idx);
        else if (p < ins_weight + 15) send_op(KIND_EXTRACT, k, idx);
        else if (p < ins_weight + 25) send_op(KIND_DELETE, k, idx);
        else if (p < ins_weight + 37) send_op(KIND_SEARCH, k, idx);
        else if (p < 97) send_op(KIND_INCR, k, idx);
        else send_op(t_kind'($urandom_range(5, 7)), k, idx);
    endtask

    initial begin
        sb = new();
        hold_cycles = 0;
        stall_random = 1'b0;
        i_rst_n = 1'b0;
        op_ch.valid = 1'b0;
        op_ch.kind = KIND_INSERT;
        op_ch.key = '0;
        op_ch.index = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty heap corners, then small-heap inserts, searches, updates and removals
        send_op(KIND_EXTRACT, 0, 0);
        send_op(KIND_DELETE, 0, 0);
        send_op(KIND_INCR, 5, 0);
        send_op(KIND_SEARCH, 0, 0);
        send_op(t_kind'(5), -1, 255);
        send_op(t_kind'(7), 0, 0);
        send_op(KIND_INSERT, KEY_MIN, 0);
        send_op(KIND_INSERT, KEY_MAX, 255);
        send_op(KIND_INSERT, 0, 0);
        send_op(KIND_INSERT, -1, 0);
        send_op(KIND_SEARCH, KEY_MIN, 0);
        send_op(KIND_SEARCH, 12345, 0);
        send_op(KIND_INCR, 7, 3);
        send_op(KIND_INCR, KEY_MIN, 0);   // decrease through increase key
        send_op(KIND_INCR, 1, 4);
        send_op(KIND_DELETE, 0, 255);
        send_op(KIND_DELETE, 0, 2);
        send_op(KIND_EXTRACT, 0, 0);
        send_op(KIND_EXTRACT, 0, 0);
        send_op(KIND_EXTRACT, 0, 0);
        send_op(KIND_EXTRACT, 0, 0);

        write_capacity(0);
        send_op(KIND_INSERT, 9, 0);
        write_capacity(1);
        send_op(KIND_INSERT, 9, 0);
        send_op(KIND_INSERT, 10, 0);
        write_capacity(9'h1FF);

        // fill with results held back so the input backs up
        hold_cycles = 400;
        for (int i = 0; i < 40; i++) random_op(80);
        drain();

        stall_random = 1'b1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_capacity(256);
                1: write_capacity(3);
                2: write_capacity(256);
                3: write_capacity(17);
                4: write_capacity(300);
                default: write_capacity(200);
            endcase
            for (int i = 0; i < 240; i++) random_op((ph % 2) ? 40 : 60);
            if (ph == 2) drain();
        end
        stall_random = 1'b0;
        for (int i = 0; i < 40; i++) random_op(40);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
